// ----- sv/lcfr_pkg.sv -----
package lcfr_pkg;

  localparam int unsigned PayloadSlotsDefault = 5;
  localparam int unsigned DataBytes = 4;
  localparam logic [7:0] SumComplement = 8'hff;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSum  = 2'd1,
    StTooLong = 2'd2,
    StEmpty   = 2'd3
  } frame_status_e;

  typedef struct packed {
    logic                      valid;
    logic [7:0]                data;
  } rx_req_t;

  typedef struct packed {
    frame_status_e             status;
    logic [7:0]                command;
    logic [DataBytes-1:0][7:0] data;
    logic [7:0]                count;
  } frame_res_t;

endpackage

// ----- sv/length_checksum_frame_receiver.sv -----
// Length-prefixed frame receiver with a ones-complement-of-sum checksum.
// Input channel (rx_valid_i, rx_stall_o, rx_byte_i): one received byte per
// request. A frame is a length byte L, L-1 payload bytes (command first, then
// data) and a checksum byte equal to 0xff minus the 8-bit payload sum.
// Output channel (res_valid_o, res_stall_i, fields): one result per frame,
// carrying status, command, four data bytes and the payload count.
// Throughput: one byte per cycle, sustained, while the output is taken.
// A closing byte is accepted into the input register; the frame state and
// that byte then form the result, which is loaded into the result register
// once it is free, and res_valid_o is driven from the result register.
// Bytes that close no frame pass even while a result waits on a stall; a byte
// that closes a frame waits in the input register until the result register
// frees, and rx_stall_o is high while it waits.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to awaiting a length byte; payload storage is not cleared.
module length_checksum_frame_receiver import lcfr_pkg::*; #(
  parameter int unsigned PAYLOAD_SLOTS = PayloadSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [1:0] frame_status_o,
  output logic [7:0] command_code_o,
  output logic [7:0] data_byte_one_o,
  output logic [7:0] data_byte_two_o,
  output logic [7:0] data_byte_three_o,
  output logic [7:0] data_byte_four_o,
  output logic [7:0] payload_count_o
);

  rx_req_t    req;
  logic       take;
  logic       res_load;
  logic       res_ready;
  frame_res_t res_next;
  frame_res_t res;

  lcfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .rx_stall_o (rx_stall_o),
    .take_i     (take),
    .req_o      (req)
  );

  lcfr_parser #(
    .PAYLOAD_SLOTS (PAYLOAD_SLOTS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .res_ready_i (res_ready),
    .take_o      (take),
    .res_load_o  (res_load),
    .res_o       (res_next)
  );

  lcfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_next),
    .res_stall_i (res_stall_i),
    .ready_o     (res_ready),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  assign frame_status_o    = res.status;
  assign command_code_o    = res.command;
  assign data_byte_one_o   = res.data[0];
  assign data_byte_two_o   = res.data[1];
  assign data_byte_three_o = res.data[2];
  assign data_byte_four_o  = res.data[3];
  assign payload_count_o   = res.count;

endmodule

// ----- sv/lcfr_in_reg.sv -----
module lcfr_in_reg import lcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_stall_o,
  input  logic       take_i,
  output rx_req_t    req_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  assign rx_stall_o = valid_q && !take_i;
  assign load       = rx_valid_i && !rx_stall_o;
  assign valid_d    = rx_stall_o ? valid_q : rx_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= rx_byte_i;
    end
  end

  assign req_o.valid = valid_q;
  assign req_o.data  = data_q;

endmodule

// ----- sv/lcfr_parser.sv -----
module lcfr_parser import lcfr_pkg::*; #(
  parameter int unsigned PAYLOAD_SLOTS = PayloadSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rx_req_t    req_i,
  input  logic       res_ready_i,
  output logic       take_o,
  output logic       res_load_o,
  output frame_res_t res_o
);

  localparam int unsigned SlotW = (PAYLOAD_SLOTS > 1) ? $clog2(PAYLOAD_SLOTS) : 1;
  localparam logic [7:0] Slots = 8'(PAYLOAD_SLOTS);

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] store_q [PAYLOAD_SLOTS];

  logic       is_len, is_body, emits;
  logic [7:0] body_idx;
  logic [7:0] count;
  logic [7:0] expect_sum;
  logic [DataBytes:0][7:0] slot_val;
  frame_status_e status;

  assign is_len     = (pos_q == 8'd0);
  assign is_body    = !is_len && (pos_q < len_q);
  assign emits      = is_len ? (req_i.data == 8'd0) : !is_body;
  assign take_o     = req_i.valid && (!emits || res_ready_i);
  assign res_load_o = req_i.valid && emits && res_ready_i;

  assign body_idx   = pos_q - 8'd1;
  assign count      = is_len ? 8'd0 : (len_q - 8'd1);
  assign expect_sum = SumComplement - sum_q;

  for (genvar k = 0; k <= DataBytes; k++) begin : g_slot
    if (k < PAYLOAD_SLOTS) begin : g_have
      assign slot_val[k] = (8'(k) < count) ? store_q[k] : 8'd0;
    end else begin : g_none
      assign slot_val[k] = 8'd0;
    end
  end

  always_comb begin
    if (is_len || len_q < 8'd2) begin
      status = StEmpty;
    end else if (count > Slots) begin
      status = StTooLong;
    end else if (expect_sum != req_i.data) begin
      status = StBadSum;
    end else begin
      status = StOk;
    end
  end

  always_comb begin
    res_o.status  = status;
    res_o.count   = count;
    res_o.command = (status == StEmpty) ? 8'd0 : slot_val[0];
    for (int k = 0; k < DataBytes; k++) begin
      res_o.data[k] = (status == StEmpty) ? 8'd0 : slot_val[k+1];
    end
  end

  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    sum_d = sum_q;
    if (take_o) begin
      if (is_len) begin
        len_d = req_i.data;
        sum_d = 8'd0;
        pos_d = (req_i.data == 8'd0) ? 8'd0 : 8'd1;
      end else if (is_body) begin
        sum_d = sum_q + req_i.data;
        pos_d = pos_q + 8'd1;
      end else begin
        pos_d = 8'd0;
        sum_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 8'd0;
      len_q <= 8'd0;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && is_body && body_idx < Slots) begin
      store_q[body_idx[SlotW-1:0]] <= req_i.data;
    end
  end

endmodule

// ----- sv/lcfr_out_reg.sv -----
module lcfr_out_reg import lcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  frame_res_t res_i,
  input  logic       res_stall_i,
  output logic       ready_o,
  output logic       res_valid_o,
  output frame_res_t res_o
);

  logic       valid_q, valid_d;
  frame_res_t res_q;

  assign ready_o = !valid_q || !res_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!res_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/lcfr_checker.sv -----
module lcfr_checker import lcfr_pkg::*; #(
  parameter int unsigned PAYLOAD_SLOTS = PayloadSlotsDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_stall_i,
  input logic [1:0] frame_status_o,
  input logic [7:0] command_code_o,
  input logic [7:0] data_byte_one_o,
  input logic [7:0] data_byte_two_o,
  input logic [7:0] data_byte_three_o,
  input logic [7:0] data_byte_four_o,
  input logic [7:0] payload_count_o
);

  localparam logic [7:0] Slots = 8'(PAYLOAD_SLOTS);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(frame_status_o)
      && $stable(command_code_o) && $stable(payload_count_o)
      && $stable(data_byte_one_o) && $stable(data_byte_two_o)
      && $stable(data_byte_three_o) && $stable(data_byte_four_o))
    else $error("stalled result changed");

  a_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && frame_status_o == StEmpty |-> payload_count_o == 8'd0
      && command_code_o == 8'd0 && data_byte_one_o == 8'd0
      && data_byte_four_o == 8'd0)
    else $error("empty frame carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (frame_status_o == StOk || frame_status_o == StBadSum)
      |-> payload_count_o != 8'd0 && payload_count_o <= Slots)
    else $error("checked frame count out of range");

  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && frame_status_o == StTooLong |-> payload_count_o > Slots)
    else $error("too-long flag on a frame that fits");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && payload_count_o < 8'd5 |-> data_byte_four_o == 8'd0)
    else $error("data beyond payload count");

endmodule

bind length_checksum_frame_receiver lcfr_checker #(
  .PAYLOAD_SLOTS (PAYLOAD_SLOTS)
) u_lcfr_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import lcfr_pkg::*;

  localparam int unsigned Slots = PayloadSlotsDefault;
  localparam int TargetBytes = 850;
  localparam int HoldAt = 150;
  localparam int HoldCycles = 300;
  localparam int PauseAt = 650;
  localparam int SteadyFrom = 350;
  localparam int SteadyTo = 550;
  localparam int IdlePct = 11;

  typedef enum int {FillRand, FillZero, FillOnes} fill_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       res_stall = 1'b0;
  logic       rx_stall;
  logic       res_valid;
  logic [1:0] frame_status;
  logic [7:0] command_code;
  logic [7:0] data_one;
  logic [7:0] data_two;
  logic [7:0] data_three;
  logic [7:0] data_four;
  logic [7:0] payload_count;

  logic [7:0] byte_q[$];
  frame_res_t frame_expect_q[$];
  int         n_bytes_total = 0;
  int         n_sent = 0;
  int         n_err = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bit         pause_done = 1'b0;

  logic [7:0] fr_pos = 8'h00;
  logic [7:0] fr_len = 8'h00;
  logic [7:0] fr_sum = 8'h00;
  logic [7:0] fr_store[Slots];

  length_checksum_frame_receiver #(
    .PAYLOAD_SLOTS(Slots)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid),
    .rx_stall_o       (rx_stall),
    .rx_byte_i        (rx_byte),
    .res_valid_o      (res_valid),
    .res_stall_i      (res_stall),
    .frame_status_o   (frame_status),
    .command_code_o   (command_code),
    .data_byte_one_o  (data_one),
    .data_byte_two_o  (data_two),
    .data_byte_three_o(data_three),
    .data_byte_four_o (data_four),
    .payload_count_o  (payload_count)
  );

  function automatic bit parse_byte(input logic [7:0] b, output frame_res_t res);
    logic [7:0] cnt;
    logic [7:0] val;
    frame_status_e st;
    res = '0;
    if (fr_pos == 8'd0) begin
      fr_len = b;
      fr_sum = 8'h00;
      if (b == 8'd0) begin
        res.status = StEmpty;
        return 1'b1;
      end
      fr_pos = 8'd1;
      return 1'b0;
    end
    if (fr_pos < fr_len) begin
      if (fr_pos <= Slots) fr_store[fr_pos - 1] = b;
      fr_sum = fr_sum + b;
      fr_pos = fr_pos + 8'd1;
      return 1'b0;
    end
    cnt = fr_len - 8'd1;
    if (fr_len < 8'd2) st = StEmpty;
    else if (cnt > Slots) st = StTooLong;
    else if ((SumComplement - fr_sum) != b) st = StBadSum;
    else st = StOk;
    res.status = st;
    res.count = cnt;
    if (st != StEmpty) begin
      for (int k = 0; k <= DataBytes; k++) begin
        val = (k < cnt && k < Slots) ? fr_store[k] : 8'h00;
        if (k == 0) res.command = val;
        else res.data[k - 1] = val;
      end
    end
    fr_pos = 8'd0;
    fr_sum = 8'h00;
    return 1'b1;
  endfunction

  task automatic add_frame(input int len, input bit good, input fill_e fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    byte_q.push_back(len[7:0]);
    if (len == 0) return;
    for (int i = 1; i < len; i++) begin
      case (fill)
        FillZero: b = 8'h00;
        FillOnes: b = 8'hff;
        default:  b = 8'($urandom);
      endcase
      sum = sum + b;
      byte_q.push_back(b);
    end
    b = SumComplement - sum;
    if (!good) b = b ^ 8'($urandom_range(1, 255));
    byte_q.push_back(b);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      n_err++;
      if (n_err <= 10)
        $display("mismatch in %s: expected %02h, got %02h", name, want, got);
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin : drive
    bit         sent;
    bit         holding;
    bit         idle_ok;
    int         cnt_now;
    frame_res_t got;
    if (!rst_ni) begin
      rx_valid <= 1'b0;
    end else begin
      sent = rx_valid && !rx_stall;
      if (sent) begin
        if (parse_byte(rx_byte, got)) frame_expect_q.push_back(got);
        n_sent <= n_sent + 1;
      end
      cnt_now = n_sent + int'(sent);
      holding = (cnt_now >= PauseAt) && !pause_done;
      if (holding && frame_expect_q.size() == 0) pause_done <= 1'b1;
      idle_ok = (cnt_now < SteadyFrom) || (cnt_now >= SteadyTo);
      if (rx_valid && !sent) begin
        // hold the stalled request
      end else if (byte_q.size() != 0 && !holding &&
                   !(idle_ok && $urandom_range(0, 99) < IdlePct)) begin
        rx_valid <= 1'b1;
        rx_byte <= byte_q.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && n_sent >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch
    frame_res_t want;
    bit         idle_ok;
    if (!rst_ni) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (frame_expect_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("result with no frame pending");
        end else begin
          want = frame_expect_q.pop_front();
          check_field("frame_status", 8'(want.status), 8'(frame_status));
          check_field("command_code", want.command, command_code);
          check_field("data_byte_one", want.data[0], data_one);
          check_field("data_byte_two", want.data[1], data_two);
          check_field("data_byte_three", want.data[2], data_three);
          check_field("data_byte_four", want.data[3], data_four);
          check_field("payload_count", want.count, payload_count);
        end
      end
      idle_ok = (n_sent < SteadyFrom) || (n_sent >= SteadyTo);
      res_stall <= (hold_left != 0) || (idle_ok && $urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    int r;
    int len;
    add_frame(0, 1'b1, FillRand);
    add_frame(1, 1'b1, FillRand);
    add_frame(2, 1'b1, FillOnes);
    add_frame(6, 1'b1, FillZero);
    add_frame(6, 1'b0, FillOnes);
    add_frame(7, 1'b1, FillRand);
    while (byte_q.size() < TargetBytes) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        byte_q.push_back(8'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) len = $urandom_range(0, 1);
        else if (r < 85) len = $urandom_range(2, 6);
        else if (r < 97) len = $urandom_range(7, 12);
        else len = $urandom_range(13, 255);
        add_frame(len, $urandom_range(0, 99) < 75, FillRand);
      end
    end
    n_bytes_total = byte_q.size();
    while (n_sent != n_bytes_total || frame_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lcfr_pkg.sv
sv/lcfr_in_reg.sv
sv/lcfr_parser.sv
sv/lcfr_out_reg.sv
sv/length_checksum_frame_receiver.sv
sv/lcfr_checker.sv
sim/tb_top.sv
